>>> rtl/kre_pkg.sv
package kre_pkg;

  localparam int ENTRIES_DEF      = 32;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int QDEPTH           = 2;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_APPEND,
    ST_RDWAIT
  } state_t;

  // one queued request
  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] payload;
    logic [4:0]  slot;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  // one result
  typedef struct packed {
    logic        hit;
    logic [4:0]  position;
    logic [31:0] key;
    logic [31:0] payload;
    logic [5:0]  entry_count;
    logic        dropped;
  } res_t;

endpackage

>>> rtl/kre_ram.sv
module kre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/kre_front.sv
module kre_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      in_op,
  input  logic [31:0]     in_key,
  input  logic [31:0]     in_payload_in,
  input  logic [4:0]      in_slot,
  output logic            busy,
  input  logic            pop,
  output kre_pkg::qhead_t head,
  output logic [1:0]      q_fill
);
  import kre_pkg::*;

  cmd_t       q_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  cmd_t       cmd_in;

  // decode the request class
  always_comb begin
    cmd_in.key     = in_key;
    cmd_in.payload = in_payload_in;
    cmd_in.slot    = in_slot;
    cmd_in.op      = op_t'(in_op);
  end

  assign busy = (fill_r == 2'(QDEPTH));
  assign push = start && !busy;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign head.valid = (fill_r != 2'd0);
  assign head.cmd   = q_r[rd_ptr_r];
  assign q_fill     = fill_r;

endmodule

>>> rtl/kre_back.sv
module kre_back #(
  parameter int ENTRIES      = kre_pkg::ENTRIES_DEF,
  parameter int PAYLOAD_BITS = kre_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kre_pkg::qhead_t              head,
  output logic                         pop,
  output logic                         res_strobe,
  output kre_pkg::res_t                res,
  output logic [$clog2(ENTRIES+1)-1:0] count
);
  import kre_pkg::*;

  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int KW  = 32;
  localparam int MW  = KW + PAYLOAD_BITS;
  localparam int SCW = (CW > 5) ? CW : 5;

  state_t          st_r, st_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            hit_r, hit_nxt;
  logic            strobe_r, strobe_nxt;
  res_t            res_r, res_nxt;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [MW-1:0]   ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [MW-1:0]   ram_rdata;

  logic [KW-1:0]            rd_key;
  logic [PAYLOAD_BITS-1:0]  rd_pl;
  logic [PAYLOAD_BITS-1:0]  cmd_pl;
  logic [PAYLOAD_BITS+31:0] in_pl_wide;
  logic [PAYLOAD_BITS+31:0] rd_pl_wide;
  logic [PAYLOAD_BITS+31:0] app_pl_wide;
  logic [SCW-1:0]           hslot_ext;
  logic [CW-1:0]            idx_ext;
  logic [CW-1:0]            idx_p1;
  logic [CW-1:0]            idx_p2;
  logic                     key_match;
  logic                     scan_last;
  logic                     shift_last;
  logic                     slot_in_range;

  function automatic logic [5:0] cnt6(input logic [CW-1:0] c);
    logic [CW+5:0] w;
    w = (CW + 6)'(c);
    return w[5:0];
  endfunction

  function automatic logic [4:0] pos5(input logic [IW-1:0] p);
    logic [IW+4:0] w;
    w = (IW + 5)'(p);
    return w[4:0];
  endfunction

  kre_ram #(
    .WIDTH (MW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key        = ram_rdata[KW-1:0];
  assign rd_pl         = ram_rdata[MW-1:KW];
  assign in_pl_wide    = (PAYLOAD_BITS + 32)'(cmd_r.payload);
  assign cmd_pl        = in_pl_wide[PAYLOAD_BITS-1:0];
  assign rd_pl_wide    = (PAYLOAD_BITS + 32)'(rd_pl);
  assign app_pl_wide   = (PAYLOAD_BITS + 32)'(cmd_pl);
  assign hslot_ext     = SCW'(head.cmd.slot);
  assign idx_ext       = CW'(idx_r);
  assign idx_p1        = idx_ext + CW'(1);
  assign idx_p2        = idx_ext + CW'(2);
  assign key_match     = (rd_key == cmd_r.key);
  assign scan_last     = (idx_p1 == cnt_r);
  assign shift_last    = (idx_p2 == cnt_r);
  assign slot_in_range = (SCW'(cmd_r.slot) < SCW'(cnt_r));

  always_comb begin
    st_nxt     = st_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    hit_nxt    = hit_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = ram_rdata;
    ram_raddr  = idx_r;

    case (st_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop     = 1'b1;
          cmd_nxt = head.cmd;
          if (head.cmd.op == OP_READ) begin
            ram_raddr = hslot_ext[IW-1:0];
            st_nxt    = ST_RDWAIT;
          end else if (cnt_r == '0) begin
            if (head.cmd.op == OP_ADD) begin
              hit_nxt = 1'b0;
              st_nxt  = ST_APPEND;
            end else begin
              strobe_nxt          = 1'b1;
              res_nxt             = '0;
              res_nxt.entry_count = cnt6(cnt_r);
            end
          end else begin
            ram_raddr = '0;
            idx_nxt   = '0;
            st_nxt    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (key_match) begin
          case (cmd_r.op)
            OP_LOOKUP: begin
              strobe_nxt          = 1'b1;
              res_nxt.hit         = 1'b1;
              res_nxt.position    = pos5(idx_r);
              res_nxt.key         = rd_key;
              res_nxt.payload     = rd_pl_wide[31:0];
              res_nxt.entry_count = cnt6(cnt_r);
              res_nxt.dropped     = 1'b0;
              st_nxt              = ST_IDLE;
            end
            OP_REMOVE: begin
              strobe_nxt          = 1'b1;
              res_nxt.hit         = 1'b1;
              res_nxt.position    = pos5(idx_r);
              res_nxt.key         = rd_key;
              res_nxt.payload     = rd_pl_wide[31:0];
              res_nxt.entry_count = cnt6(cnt_r - CW'(1));
              res_nxt.dropped     = 1'b0;
              if (scan_last) begin
                cnt_nxt = cnt_r - CW'(1);
                st_nxt  = ST_IDLE;
              end else begin
                ram_raddr = idx_p1[IW-1:0];
                st_nxt    = ST_SHIFT;
              end
            end
            default: begin
              hit_nxt = 1'b1;
              if (scan_last) begin
                cnt_nxt = cnt_r - CW'(1);
                st_nxt  = ST_APPEND;
              end else begin
                ram_raddr = idx_p1[IW-1:0];
                st_nxt    = ST_SHIFT;
              end
            end
          endcase
        end else if (scan_last) begin
          if (cmd_r.op == OP_ADD) begin
            hit_nxt = 1'b0;
            st_nxt  = ST_APPEND;
          end else begin
            strobe_nxt          = 1'b1;
            res_nxt             = '0;
            res_nxt.entry_count = cnt6(cnt_r);
            st_nxt              = ST_IDLE;
          end
        end else begin
          ram_raddr = idx_p1[IW-1:0];
          idx_nxt   = idx_p1[IW-1:0];
        end
      end

      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        if (shift_last) begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt  = (cmd_r.op == OP_ADD) ? ST_APPEND : ST_IDLE;
        end else begin
          ram_raddr = idx_p2[IW-1:0];
          idx_nxt   = idx_p1[IW-1:0];
        end
      end

      ST_APPEND: begin
        strobe_nxt = 1'b1;
        st_nxt     = ST_IDLE;
        if (cnt_r == CW'(ENTRIES)) begin
          res_nxt             = '0;
          res_nxt.dropped     = 1'b1;
          res_nxt.entry_count = cnt6(cnt_r);
        end else begin
          ram_we              = 1'b1;
          ram_waddr           = cnt_r[IW-1:0];
          ram_wdata           = {cmd_pl, cmd_r.key};
          cnt_nxt             = cnt_r + CW'(1);
          res_nxt.hit         = hit_r;
          res_nxt.position    = pos5(cnt_r[IW-1:0]);
          res_nxt.key         = cmd_r.key;
          res_nxt.payload     = app_pl_wide[31:0];
          res_nxt.entry_count = cnt6(cnt_r + CW'(1));
          res_nxt.dropped     = 1'b0;
        end
      end

      ST_RDWAIT: begin
        strobe_nxt          = 1'b1;
        st_nxt              = ST_IDLE;
        res_nxt.hit         = slot_in_range;
        res_nxt.position    = cmd_r.slot;
        res_nxt.key         = slot_in_range ? rd_key : '0;
        res_nxt.payload     = slot_in_range ? rd_pl_wide[31:0] : '0;
        res_nxt.entry_count = cnt6(cnt_r);
        res_nxt.dropped     = 1'b0;
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    res_r <= res_nxt;
  end

  assign res_strobe = strobe_r;
  assign res        = res_r;
  assign count      = cnt_r;

endmodule

>>> rtl/keyed_registry_table_top.sv
// Channel   Direction  Handshake                    Ports
// request   in         start high while busy low    in_op in_key in_payload_in in_slot
// result    out        out_strobe, one cycle        out_hit out_position out_key_out
//                                                   out_payload_out out_entry_count out_dropped
//
// A read fetches the addressed slot and reports it; lookup and remove scan one stored key
// per cycle from position 0 and report at a match, or after the last key on a miss; add
// scans, compacts on a match and appends. Remove and add compact the table at one entry
// per cycle, holding off the next request. A two-deep queue takes requests meanwhile;
// busy rises only when it is full. Synchronous reset empties the queue and zeroes the
// count, leaving table contents; the receiver cannot stall.
module keyed_registry_table_top #(
  parameter int ENTRIES      = kre_pkg::ENTRIES_DEF,
  parameter int PAYLOAD_BITS = kre_pkg::PAYLOAD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_key,
  input  logic [31:0] in_payload_in,
  input  logic [4:0]  in_slot,
  output logic        out_strobe,
  output logic        out_hit,
  output logic [4:0]  out_position,
  output logic [31:0] out_key_out,
  output logic [31:0] out_payload_out,
  output logic [5:0]  out_entry_count,
  output logic        out_dropped
);
  import kre_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  qhead_t        head;
  logic          pop;
  logic [1:0]    q_fill;
  res_t          res;
  logic [CW-1:0] count;

  // front end: take the request, decode it and hold it in the queue
  kre_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_op         (in_op),
    .in_key        (in_key),
    .in_payload_in (in_payload_in),
    .in_slot       (in_slot),
    .busy          (busy),
    .pop           (pop),
    .head          (head),
    .q_fill        (q_fill)
  );

  // back end: scan, compact and append against the table RAM
  kre_back #(
    .ENTRIES      (ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .res_strobe (out_strobe),
    .res        (res),
    .count      (count)
  );

  // drive the result ports straight from the back end's output register
  assign out_hit         = res.hit;
  assign out_position    = res.position;
  assign out_key_out     = res.key;
  assign out_payload_out = res.payload;
  assign out_entry_count = res.entry_count;
  assign out_dropped     = res.dropped;

  // an accepted request must land in the queue
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> q_fill != 2'd0)
    else $error("accepted request missing from queue");

  // the back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_fill != 2'd0)
    else $error("pop from empty queue");

  // the table count stays within its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(ENTRIES))
    else $error("entry count beyond capacity");

  // a refused add only comes from a full table and never reports a hit
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_dropped |-> !out_hit && count == CW'(ENTRIES))
    else $error("drop flagged on a table that is not full");

endmodule
